/* hw/rtl/pbt_pkg.sv */
// Shared types and codes for the port binding table.
// Holds the request/result beats, the probe that sweeps the cell row and the
// write-back command. No dependencies.
package pbt_pkg;

    // Slot numbers travel at a fixed width that covers the largest table.
    localparam int SLOT_W = 8;

    localparam logic [1:0] REQ_BIND   = 2'd0;
    localparam logic [1:0] REQ_UNBIND = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IN_USE    = 3'd1;
    localparam logic [2:0] ST_ZERO      = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        proto_is_tcp;
        logic [15:0] port_number;
        logic [31:0] owner_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [31:0] found_owner;
        logic [3:0]  slot_index;
        logic        reply_is_tcp;
    } t_result;

    // Request plus what the cells seen so far have reported.
    typedef struct packed {
        logic              valid;
        logic [1:0]        req_type;
        logic              key_tcp;
        logic [15:0]       port;
        logic [31:0]       owner;
        logic              found;
        logic [SLOT_W-1:0] found_slot;
        logic [31:0]       found_owner;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
    } t_probe;

    // Write-back broadcast to every cell; only the addressed cell acts.
    typedef struct packed {
        logic              en;
        logic              clr;
        logic [SLOT_W-1:0] slot;
        logic              tcp;
        logic [15:0]       port;
        logic [31:0]       owner;
    } t_wr;

endpackage

/* hw/rtl/pbt_cell.sv */
// One table entry of the port binding table, with its stage of the probe row.
// Compares the passing probe against its entry and forwards it one cell on.
// Depends on pbt_pkg.
module pbt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbt_pkg::t_probe i_probe,
    input  pbt_pkg::t_wr    i_wr,
    output pbt_pkg::t_probe o_probe
);
    import pbt_pkg::*;

    logic        r_valid;
    logic        r_tcp;
    logic [15:0] r_port;
    logic [31:0] r_owner;
    t_probe      r_probe;
    t_probe      n_probe;
    logic        w_match;
    logic        w_sel;

    assign w_match = r_valid && (r_tcp == i_probe.key_tcp) && (r_port == i_probe.port);
    assign w_sel   = i_wr.en && (i_wr.slot == SLOT_W'(CELL_IDX));

    always_comb begin
        n_probe = i_probe;
        // First hit and first free slot win: lower cells were visited earlier.
        if (!i_probe.found && w_match) begin
            n_probe.found       = 1'b1;
            n_probe.found_slot  = SLOT_W'(CELL_IDX);
            n_probe.found_owner = r_owner;
        end
        if (!i_probe.free_found && !r_valid) begin
            n_probe.free_found = 1'b1;
            n_probe.free_slot  = SLOT_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
            if (w_sel) begin
                r_valid <= !i_wr.clr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && !i_wr.clr) begin
            r_tcp   <= i_wr.tcp;
            r_port  <= i_wr.port;
            r_owner <= i_wr.owner;
        end
    end

    assign o_probe = r_probe;

endmodule

/* hw/rtl/port_binding_table_core.sv */
// Port binding table core: probe loader, row of pbt_cell entries and write-back; needs pbt_pkg.
// Result path: start is registered into the probe head, then each cell's probe register, then the strobe.
// One request at a time: the probe walks the cell row
// one entry per cycle and busy stays high until it leaves the last cell.
// The write-back lands at the edge that ends the strobe cycle, where start may
// be taken again. The receiver cannot stall. Synchronous reset empties the table.
module port_binding_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  pbt_pkg::t_req    i_req,
    output logic             busy,
    output logic             o_strobe,
    output pbt_pkg::t_result o_result
);
    import pbt_pkg::*;

    t_probe  w_probe [ENTRIES+1];
    t_probe  r_probe;
    t_probe  w_tail;
    t_wr     r_wr;
    t_wr     n_wr;
    t_result r_result;
    t_result n_result;
    logic    r_busy;
    logic    r_strobe;
    logic    w_accept;

    assign w_accept = start && !r_busy;

    // Load the probe head; unbind always keys on UDP.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= w_accept;
            if (w_accept) begin
                r_probe.req_type    <= i_req.req_type;
                r_probe.key_tcp     <= (i_req.req_type == REQ_UNBIND) ? 1'b0 : i_req.proto_is_tcp;
                r_probe.port        <= i_req.port_number;
                r_probe.owner       <= i_req.owner_id;
                r_probe.found       <= 1'b0;
                r_probe.found_slot  <= '0;
                r_probe.found_owner <= '0;
                r_probe.free_found  <= 1'b0;
                r_probe.free_slot   <= '0;
            end
        end
    end

    assign w_probe[0] = r_probe;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        pbt_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_probe[g]),
            .i_wr    (r_wr),
            .o_probe (w_probe[g+1])
        );
    end

    assign w_tail = w_probe[ENTRIES];

    always_comb begin
        n_result              = '0;
        n_result.status       = ST_NOT_FOUND;
        n_result.reply_is_tcp = w_tail.key_tcp;
        n_wr                  = '0;
        n_wr.slot             = w_tail.free_slot;
        n_wr.tcp              = w_tail.key_tcp;
        n_wr.port             = w_tail.port;
        n_wr.owner            = w_tail.owner;
        case (w_tail.req_type)
            REQ_BIND: begin
                if (w_tail.owner == '0 || w_tail.port == '0) begin
                    n_result.status = ST_ZERO;
                end else if (w_tail.found) begin
                    n_result.status      = ST_IN_USE;
                    n_result.hit         = 1'b1;
                    n_result.found_owner = w_tail.found_owner;
                    n_result.slot_index  = w_tail.found_slot[3:0];
                end else if (!w_tail.free_found) begin
                    n_result.status = ST_FULL;
                end else begin
                    n_result.status     = ST_OK;
                    n_result.slot_index = w_tail.free_slot[3:0];
                    n_wr.en             = w_tail.valid;
                end
            end
            REQ_UNBIND: begin
                if (w_tail.port == '0) begin
                    n_result.status = ST_ZERO;
                end else if (w_tail.found) begin
                    n_result.status      = ST_OK;
                    n_result.hit         = 1'b1;
                    n_result.found_owner = w_tail.found_owner;
                    n_result.slot_index  = w_tail.found_slot[3:0];
                    n_wr.en              = w_tail.valid;
                    n_wr.clr             = 1'b1;
                    n_wr.slot            = w_tail.found_slot;
                end
            end
            REQ_LOOKUP: begin
                if (w_tail.found) begin
                    n_result.status      = ST_OK;
                    n_result.hit         = 1'b1;
                    n_result.found_owner = w_tail.found_owner;
                    n_result.slot_index  = w_tail.found_slot[3:0];
                end
            end
            default: begin
                n_result.status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_wr.en  <= 1'b0;
        end else begin
            r_strobe <= w_tail.valid;
            r_wr.en  <= n_wr.en;
            if (w_tail.valid) begin
                r_wr.clr   <= n_wr.clr;
                r_wr.slot  <= n_wr.slot;
                r_wr.tcp   <= n_wr.tcp;
                r_wr.port  <= n_wr.port;
                r_wr.owner <= n_wr.owner;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.valid) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !busy))
        else $error("strobe without a request in flight");

    a_write_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr.en |-> (o_strobe && o_result.status == ST_OK))
        else $error("table write without a successful result");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.hit) |->
            (o_result.status == ST_OK || o_result.status == ST_IN_USE))
        else $error("hit reported with a failing status");
`endif

endmodule

/* sim/tb_port_binding_table_core.sv */
// Testbench for port_binding_table_core: directed table of bind, unbind and lookup beats,
// then random traffic over small port pools, checked against a local binding table model.
// Depends on pbt_pkg and the core RTL only.
module tb_port_binding_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pbt_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int CLK_PERIOD   = 4;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int UDP_POOL     = 14;
    localparam int TCP_POOL     = 4;

    // Request code the core leaves unused.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct {
        t_req    req;
        bit      typed;
        t_result want;
    } t_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_req    i_req = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // Typed expectation that travels with the beat on i_req.
    logic    row_typed = 1'b0;
    t_result row_want = '0;

    // Shadow copy of the binding table.
    logic        bind_valid [ENTRIES];
    logic        bind_tcp   [ENTRIES];
    logic [15:0] bind_port  [ENTRIES];
    logic [31:0] bind_owner [ENTRIES];

    t_result     pending_replies[$];
    t_row        script[$];
    logic [15:0] udp_ports[UDP_POOL];
    logic [15:0] tcp_ports[TCP_POOL];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          idle_plan[4] = '{0, 46, 0, 7};
    t_result     reply_want;
    t_result     reply_pred;

    port_binding_table_core #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        if (mismatch_count < 40) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Lowest valid slot holding the key, or -1.
    function automatic int find_key(input logic tcp, input logic [15:0] port);
        for (int k = 0; k < ENTRIES; k++) begin
            if (bind_valid[k] && bind_tcp[k] == tcp && bind_port[k] == port) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic t_result predict_binding(input t_req r);
        t_result res;
        int      k;
        res = '0;
        res.status = ST_NOT_FOUND;
        res.reply_is_tcp = r.proto_is_tcp;
        case (r.req_type)
            REQ_BIND: begin
                if (r.owner_id == '0 || r.port_number == '0) begin
                    res.status = ST_ZERO;
                end else begin
                    k = find_key(r.proto_is_tcp, r.port_number);
                    if (k >= 0) begin
                        res.status = ST_IN_USE;
                        res.hit = 1'b1;
                        res.found_owner = bind_owner[k];
                        res.slot_index = k[3:0];
                    end else begin
                        k = -1;
                        for (int j = ENTRIES - 1; j >= 0; j--) begin
                            if (!bind_valid[j]) k = j;
                        end
                        if (k < 0) begin
                            res.status = ST_FULL;
                        end else begin
                            bind_valid[k] = 1'b1;
                            bind_tcp[k]   = r.proto_is_tcp;
                            bind_port[k]  = r.port_number;
                            bind_owner[k] = r.owner_id;
                            res.status = ST_OK;
                            res.slot_index = k[3:0];
                        end
                    end
                end
            end
            REQ_UNBIND: begin
                res.reply_is_tcp = 1'b0;
                if (r.port_number == '0) begin
                    res.status = ST_ZERO;
                end else begin
                    k = find_key(1'b0, r.port_number);
                    if (k >= 0) begin
                        res.status = ST_OK;
                        res.hit = 1'b1;
                        res.found_owner = bind_owner[k];
                        res.slot_index = k[3:0];
                        bind_valid[k] = 1'b0;
                        bind_tcp[k]   = 1'b0;
                        bind_port[k]  = '0;
                        bind_owner[k] = '0;
                    end
                end
            end
            REQ_LOOKUP: begin
                k = find_key(r.proto_is_tcp, r.port_number);
                if (k >= 0) begin
                    res.status = ST_OK;
                    res.hit = 1'b1;
                    res.found_owner = bind_owner[k];
                    res.slot_index = k[3:0];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic tcp,
                                    input logic [15:0] port, input logic [31:0] owner,
                                    input bit typed, input logic [2:0] status,
                                    input logic hit, input logic [31:0] found,
                                    input logic [3:0] slot, input logic echo);
        t_row row;
        row.req   = '{req_type: op, proto_is_tcp: tcp, port_number: port, owner_id: owner};
        row.typed = typed;
        row.want  = '{status: status, hit: hit, found_owner: found,
                      slot_index: slot, reply_is_tcp: echo};
        script.push_back(row);
    endfunction

    // Mostly bind/unbind/lookup over the port pools; a few malformed beats.
    function automatic t_req random_req();
        t_req r;
        int   sel;
        if ($urandom_range(99) < 2) begin
            udp_ports[$urandom_range(UDP_POOL - 1)] = 16'($urandom_range(65535, 1));
        end
        r.proto_is_tcp = ($urandom_range(3) == 0);
        r.port_number  = r.proto_is_tcp ? tcp_ports[$urandom_range(TCP_POOL - 1)]
                                        : udp_ports[$urandom_range(UDP_POOL - 1)];
        r.owner_id     = ($urandom_range(99) < 3) ? 32'd0 : 32'($urandom);
        sel = $urandom_range(99);
        if (sel < 45) begin
            r.req_type = REQ_BIND;
        end else if (sel < 68) begin
            r.req_type = REQ_UNBIND;
        end else if (sel < 94) begin
            r.req_type = REQ_LOOKUP;
        end else if (sel < 97) begin
            r.req_type = REQ_SPARE;
        end else begin
            r.req_type    = 2'($urandom_range(3));
            r.port_number = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535));
        end
        return r;
    endfunction

    // Hold the beat until the core takes it; idle first at the given rate.
    task automatic send_beat(input t_req r, input bit typed, input t_result want,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_req     <= r;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge i_clk); while (busy);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n) begin
            // Retire the result first: a new beat may be taken on the same edge.
            if (o_strobe) begin
                if (pending_replies.size() == 0) begin
                    flag_error("result beat with no request pending");
                end else begin
                    reply_want = pending_replies.pop_front();
                    if (o_result.status !== reply_want.status)
                        flag_error($sformatf("status got %0d want %0d",
                                             o_result.status, reply_want.status));
                    if (o_result.hit !== reply_want.hit)
                        flag_error($sformatf("hit got %0d want %0d",
                                             o_result.hit, reply_want.hit));
                    if (o_result.found_owner !== reply_want.found_owner)
                        flag_error($sformatf("found_owner got %h want %h",
                                             o_result.found_owner, reply_want.found_owner));
                    if (o_result.slot_index !== reply_want.slot_index)
                        flag_error($sformatf("slot_index got %0d want %0d",
                                             o_result.slot_index, reply_want.slot_index));
                    if (o_result.reply_is_tcp !== reply_want.reply_is_tcp)
                        flag_error($sformatf("reply_is_tcp got %0d want %0d",
                                             o_result.reply_is_tcp, reply_want.reply_is_tcp));
                end
            end
            if (start && !busy) begin
                reply_pred = predict_binding(i_req);
                pending_replies.push_back(row_typed ? row_want : reply_pred);
            end
        end
    end

    initial begin
        t_req r;
        for (int k = 0; k < ENTRIES; k++) begin
            bind_valid[k] = 1'b0;
            bind_tcp[k]   = 1'b0;
            bind_port[k]  = '0;
            bind_owner[k] = '0;
        end
        // Start the UDP pool on the ports the directed fill leaves bound.
        for (int i = 0; i < UDP_POOL; i++) udp_ports[i] = 16'h0001 << (i + 2);
        tcp_ports[0] = 16'hFFFF;
        for (int i = 1; i < TCP_POOL; i++) tcp_ports[i] = 16'($urandom_range(65535, 1));

        add_row(REQ_LOOKUP, 1'b0, 16'h0000, 32'h0000_0000, 1, ST_NOT_FOUND, 0, 0, 0, 0);
        add_row(REQ_BIND,   1'b0, 16'h0000, 32'h0000_0005, 1, ST_ZERO, 0, 0, 0, 0);
        add_row(REQ_BIND,   1'b1, 16'hFFFF, 32'h0000_0000, 1, ST_ZERO, 0, 0, 0, 1);
        add_row(REQ_UNBIND, 1'b1, 16'h0000, 32'hFFFF_FFFF, 1, ST_ZERO, 0, 0, 0, 0);
        add_row(REQ_UNBIND, 1'b0, 16'h8000, 32'h0000_0000, 1, ST_NOT_FOUND, 0, 0, 0, 0);
        add_row(REQ_BIND,   1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1, ST_OK, 0, 0, 0, 0);
        add_row(REQ_BIND,   1'b1, 16'hFFFF, 32'h0000_0001, 1, ST_OK, 0, 0, 1, 1);
        add_row(REQ_BIND,   1'b0, 16'hFFFF, 32'h1234_5678, 1, ST_IN_USE, 1,
                32'hFFFF_FFFF, 0, 0);
        add_row(REQ_LOOKUP, 1'b1, 16'hFFFF, 32'h0000_0000, 1, ST_OK, 1, 32'h0000_0001, 1, 1);
        add_row(REQ_SPARE,  1'b1, 16'h0001, 32'h0000_0007, 1, ST_NOT_FOUND, 0, 0, 0, 1);
        // Fill the remaining slots with walking-one UDP ports.
        for (int k = 2; k < ENTRIES; k++) begin
            add_row(REQ_BIND, 1'b0, 16'h0001 << k, 32'($urandom) | 32'd1, 0, '0, 0, 0, 0, 0);
        end
        add_row(REQ_BIND,   1'b1, 16'h7FFF, 32'h8000_0000, 1, ST_FULL, 0, 0, 0, 1);
        add_row(REQ_UNBIND, 1'b0, 16'hFFFF, 32'h0000_0000, 1, ST_OK, 1,
                32'hFFFF_FFFF, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) send_beat(script[i].req, script[i].typed, script[i].want, 0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                r = random_req();
                send_beat(r, 1'b0, '0, idle_plan[ph]);
            end
        end
        start <= 1'b0;

        // Drain, then leave room for any stray strobe.
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
